>>> rtl/core/tcce_pkg.sv
// package with request kinds, character codes and register constants for the text console
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

    // request kinds carried in s_tuser
    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2
    } req_kind_t;

    // control characters interpreted by a put request
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // tab stops sit on multiples of eight columns
    localparam int unsigned TAB_STEP = 8;

    // attribute register
    localparam logic [7:0] ATTR_RESET     = 8'h07;
    localparam int unsigned PADDR_W       = 3;
    localparam logic [0:0] REG_TEXT_ATTR  = 1'b0;

    // payload field widths
    localparam int unsigned CELL_W    = 16;
    localparam int unsigned OUT_COL_W = 7;
    localparam int unsigned OUT_ROW_W = 5;
    localparam int unsigned IN_ROW_W  = 5;
    localparam int unsigned IN_COL_W  = 7;
    localparam int unsigned WROW_W    = 6;

endpackage

`default_nettype wire

>>> rtl/core/text_console_cursor_engine.sv
// text console cursor engine: screen store, cursor sequencer and stream/apb ports
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    s_tuser req_type, s_tdata char_code, cell_row, cell_col
// m_        out  m_tvalid / m_tready    m_tdata cell_word, cursor_col, cursor_row
// apb       in   psel, penable, pready  paddr, pwdata, prdata (text_attribute at byte 0)
//
// one beat at a time through a small sequencer around a single-port-write screen store;
// from accept to result register a plain or control put passes decode, put, addr, write and
// resp, a read passes decode, addr, rdwait and resp, and an unused kind goes from decode to resp;
// a put that scrolls adds a copy loop of read and write states, then a bottom-row fill; a clear
// runs a fill over every cell (one store write per cycle). after reset a clearing pass writes
// every cell once with s_tready low; the apb port takes writes throughout. a result waiting on
// m_tready holds the sequencer in its response state until the beat leaves.

module text_console_cursor_engine
    import tcce_pkg::*;
#(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [7:0] char_code, [12:8] cell_row, [19:13] cell_col, [23:20] zero
    input  wire logic [23:0]         s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]          s_tuser,

    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [15:0] cell_word, [22:16] cursor_col, [27:23] cursor_row, [31:28] zero
    output logic [31:0]              m_tdata,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int unsigned CELLS = ROWS * COLUMNS;
    localparam int unsigned AW    = $clog2(CELLS);
    localparam int unsigned CW    = $clog2(COLUMNS);
    localparam int unsigned CXW   = $clog2(COLUMNS + TAB_STEP);
    localparam int unsigned RW    = $clog2(ROWS);
    localparam int unsigned RXW   = $clog2(ROWS + 1);

    localparam logic [AW-1:0]  COLS_A     = AW'(COLUMNS);
    localparam logic [AW-1:0]  LAST_A     = AW'(CELLS - 1);
    localparam logic [AW-1:0]  BOTTOM_A   = AW'(CELLS - COLUMNS);
    localparam logic [CXW-1:0] COLS_X     = CXW'(COLUMNS);
    localparam logic [CXW-1:0] LAST_COL_X = CXW'(COLUMNS - 1);
    localparam logic [CXW-1:0] TAB_X      = CXW'(TAB_STEP);
    localparam logic [CXW-1:0] TAB_MASK_X = ~CXW'(TAB_STEP - 1);
    localparam logic [RXW-1:0] ROWS_X     = RXW'(ROWS);
    localparam logic [RXW-1:0] LAST_ROW_X = RXW'(ROWS - 1);

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_DECODE,
        ST_PUT,
        ST_ADDR,
        ST_RDWAIT,
        ST_WRITE,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_RESP
    } state_t;

    state_t                state_reg;
    req_kind_t             kind_reg;
    logic [7:0]            ch_reg;
    logic [WROW_W-1:0]     wrow_reg;
    logic [IN_COL_W-1:0]   wcol_reg;
    logic                  rd_ok_reg;
    logic [CW-1:0]         cur_col_reg;
    logic [RW-1:0]         cur_row_reg;
    logic [AW-1:0]         addr_reg;
    logic                  init_reg;
    logic                  we_pend_reg;
    logic                  scroll_reg;
    logic [CELL_W-1:0]     wdata_reg;
    logic [CELL_W-1:0]     rdata_reg;
    logic [7:0]            attr_reg;
    logic                  m_tvalid_reg;
    logic [31:0]           m_tdata_reg;

    // screen store
    logic [CELL_W-1:0]     screen_mem [CELLS];
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [CELL_W-1:0]     mem_wdata;

    logic [CELL_W-1:0]     blank_cell;
    logic [AW-1:0]         addr_calc;

    // put decode results
    logic [CXW-1:0]        put_col;
    logic [RXW-1:0]        put_row;
    logic                  put_we;
    logic [CW-1:0]         put_wcol;
    logic [CELL_W-1:0]     put_wdata;
    logic                  put_scroll;
    logic [CXW-1:0]        col_x;
    logic [RXW-1:0]        row_x;

    logic                  cfg_wr;
    logic [CELL_W-1:0]     resp_word;
    logic [OUT_COL_W+CW-1:0] col_ext;
    logic [OUT_ROW_W+RW-1:0] row_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;

    // apb register
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == REG_TEXT_ATTR);
    assign prdata = (paddr[PADDR_W-1] == REG_TEXT_ATTR) ? {24'd0, attr_reg} : 32'd0;

    // the reset pass writes the reset blank even if the attribute is rewritten meanwhile
    assign blank_cell = init_reg ? {ATTR_RESET, CH_SPACE} : {attr_reg, CH_SPACE};

    // shared address unit: row * COLUMNS + column
    assign addr_calc = AW'(AW'(wrow_reg) * COLS_A + AW'(wcol_reg));

    // put request: new cursor, cell write and scroll decision
    always_comb begin
        col_x      = CXW'(cur_col_reg);
        row_x      = RXW'(cur_row_reg);
        put_col    = col_x;
        put_row    = row_x;
        put_we     = 1'b0;
        put_wcol   = cur_col_reg;
        put_wdata  = {attr_reg, ch_reg};
        put_scroll = 1'b0;
        priority if (ch_reg == CH_NEWLINE) begin
            put_col = '0;
            put_row = row_x + RXW'(1);
        end else if (ch_reg == CH_RETURN) begin
            put_col = '0;
        end else if (ch_reg == CH_TAB) begin
            put_col = (col_x + TAB_X) & TAB_MASK_X;
        end else if (ch_reg == CH_BACKSPACE) begin
            if (cur_col_reg != '0) begin
                // erase the cell to the left
                put_col   = col_x - CXW'(1);
                put_we    = 1'b1;
                put_wcol  = cur_col_reg - CW'(1);
                put_wdata = blank_cell;
            end else if (cur_row_reg != '0) begin
                // back to the end of the previous line, nothing erased
                put_row = row_x - RXW'(1);
                put_col = LAST_COL_X;
            end
        end else begin
            put_we  = 1'b1;
            put_col = col_x + CXW'(1);
        end
        // line wrap, then scroll past the bottom row
        if (put_col >= COLS_X) begin
            put_col = '0;
            put_row = put_row + RXW'(1);
        end
        if (put_row >= ROWS_X) begin
            put_scroll = 1'b1;
            put_row    = LAST_ROW_X;
        end
    end

    // store write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = blank_cell;
        unique case (state_reg)
            ST_FILL: begin
                mem_we = 1'b1;
            end
            ST_WRITE: begin
                mem_we    = we_pend_reg;
                mem_wdata = wdata_reg;
            end
            ST_SCR_WR: begin
                // copy one row up
                mem_we    = 1'b1;
                mem_waddr = addr_reg - COLS_A;
                mem_wdata = rdata_reg;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= screen_mem[addr_reg];
    end

    // result beat fields
    assign resp_word = (kind_reg == REQ_READ && rd_ok_reg) ? rdata_reg : '0;
    assign col_ext   = {{OUT_COL_W{1'b0}}, cur_col_reg};
    assign row_ext   = {{OUT_ROW_W{1'b0}}, cur_row_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (cfg_wr) begin
            attr_reg <= pwdata[7:0];
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            addr_reg     <= '0;
            init_reg     <= 1'b1;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            we_pend_reg  <= 1'b0;
            scroll_reg   <= 1'b0;
        end else begin
            // the response state handles a leaving beat itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_RESP)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_FILL: begin
                    if (addr_reg == LAST_A) begin
                        init_reg  <= 1'b0;
                        state_reg <= init_reg ? ST_IDLE : ST_RESP;
                    end else begin
                        addr_reg <= addr_reg + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg  <= req_kind_t'(s_tuser);
                        ch_reg    <= s_tdata[7:0];
                        wrow_reg  <= WROW_W'(s_tdata[12:8]);
                        wcol_reg  <= s_tdata[19:13];
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    unique case (kind_reg)
                        REQ_PUT: begin
                            state_reg <= ST_PUT;
                        end
                        REQ_CLEAR: begin
                            cur_col_reg <= '0;
                            cur_row_reg <= '0;
                            addr_reg    <= '0;
                            state_reg   <= ST_FILL;
                        end
                        REQ_READ: begin
                            rd_ok_reg <= ({1'b0, wrow_reg} < 7'(ROWS))
                                      && ({1'b0, wcol_reg} < 8'(COLUMNS));
                            state_reg <= ST_ADDR;
                        end
                        default: begin
                            state_reg <= ST_RESP;
                        end
                    endcase
                end
                ST_PUT: begin
                    wrow_reg    <= WROW_W'(cur_row_reg);
                    wcol_reg    <= IN_COL_W'(put_wcol);
                    we_pend_reg <= put_we;
                    wdata_reg   <= put_wdata;
                    scroll_reg  <= put_scroll;
                    cur_col_reg <= CW'(put_col);
                    cur_row_reg <= RW'(put_row);
                    state_reg   <= ST_ADDR;
                end
                ST_ADDR: begin
                    addr_reg  <= addr_calc;
                    state_reg <= (kind_reg == REQ_READ) ? ST_RDWAIT : ST_WRITE;
                end
                ST_RDWAIT: begin
                    state_reg <= ST_RESP;
                end
                ST_WRITE: begin
                    if (scroll_reg) begin
                        addr_reg  <= COLS_A;
                        state_reg <= ST_SCR_RD;
                    end else begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_SCR_RD: begin
                    state_reg <= ST_SCR_WR;
                end
                ST_SCR_WR: begin
                    if (addr_reg == LAST_A) begin
                        // copy done, blank the bottom row
                        addr_reg  <= BOTTOM_A;
                        state_reg <= ST_FILL;
                    end else begin
                        addr_reg  <= addr_reg + AW'(1);
                        state_reg <= ST_SCR_RD;
                    end
                end
                ST_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, row_ext[OUT_ROW_W-1:0],
                                         col_ext[OUT_COL_W-1:0], resp_word};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // one beat in flight: an accept is never followed directly by another
    a_single_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while busy");

    // cursor stays on the screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, cur_row_reg} < (RW + 1)'(ROWS)) && ({1'b0, cur_col_reg} < (CW + 1)'(COLUMNS)))
        else $error("cursor off screen");

    // the store is untouched while waiting for a request
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !mem_we)
        else $error("store written while idle");

    // a new result never lands on a beat that has not left
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// testbench for the text console cursor engine: requests checked against a screen model
`timescale 1ns / 1ps

module tb_top
    import tcce_pkg::*;
();

    // screen geometry handed to the block and to the screen model
    localparam int unsigned COLUMNS = 80;
    localparam int unsigned ROWS    = 25;
    localparam int unsigned CELLS   = COLUMNS * ROWS;

    // request kind the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // run shape
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned PHASE_ITEMS   = 130;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned HOLD_AT_REPLY = 60;

    // timeout: every beat scrolling, every beat waiting out the longest gap and stall,
    // plus the clearing pass after reset and the long hold-off, then four times over
    localparam int unsigned SCROLL_CYCLES = 2 * (ROWS - 1) * COLUMNS + COLUMNS;
    localparam int unsigned MAX_ITEMS     = 25 + RANDOM_PHASES * PHASE_ITEMS;
    localparam int unsigned CYCLE_LIMIT   = 4 * (MAX_ITEMS * (SCROLL_CYCLES + 40) + CELLS
                                            + LONG_HOLD + RANDOM_PHASES * 40);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
    } console_req_t;

    typedef struct packed {
        logic [15:0] cell_word;
        logic [6:0]  col;
        logic [4:0]  row;
    } console_reply_t;

    // block ports, all inputs known from time zero
    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata  = '0;  // [7:0] char_code, [12:8] cell_row, [19:13] cell_col
    logic [1:0]          s_tuser  = '0;  // [1:0] req_type
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;  // [15:0] cell_word, [22:16] cursor_col, [27:23] cursor_row
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    // screen model state
    logic [15:0]  shadow_screen [CELLS];
    int unsigned  shadow_col;
    int unsigned  shadow_row;
    logic [7:0]   shadow_attr;

    // requests waiting for the driver, replies waiting for the block
    console_req_t   pending_reqs[$];
    console_reply_t expected_replies[$];
    console_req_t   next_req;
    console_reply_t want;

    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned replies_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;

    // handshake and idling control
    bit          s_accepted = 1'b0;
    bit          tx_idle_on = 1'b0;
    bit          rx_idle_on = 1'b0;
    bit          hold_done  = 1'b0;
    int unsigned tx_gap     = 0;
    int unsigned rx_stall   = 0;
    int unsigned rx_hold    = 0;

    text_console_cursor_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // every cell becomes a space in the current attribute
    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) begin
            shadow_screen[i] = {shadow_attr, CH_SPACE};
        end
    endfunction

    // applies one request to the screen model and returns the reply it should produce
    function automatic console_reply_t console_step(console_req_t rq);
        console_reply_t rp;
        rp = '0;
        if (rq.kind == REQ_PUT) begin
            if (rq.ch == CH_NEWLINE) begin
                shadow_col = 0;
                shadow_row++;
            end else if (rq.ch == CH_RETURN) begin
                shadow_col = 0;
            end else if (rq.ch == CH_TAB) begin
                // next tab stop, may land one past the right edge
                shadow_col = (shadow_col + TAB_STEP) & ~(TAB_STEP - 1);
            end else if (rq.ch == CH_BACKSPACE) begin
                if (shadow_col > 0) begin
                    // erase the cell to the left
                    shadow_col--;
                    shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, CH_SPACE};
                end else if (shadow_row > 0) begin
                    // back to the end of the line above, nothing erased
                    shadow_row--;
                    shadow_col = COLUMNS - 1;
                end
            end else begin
                shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, rq.ch};
                shadow_col++;
            end
            if (shadow_col >= COLUMNS) begin
                shadow_col = 0;
                shadow_row++;
            end
            if (shadow_row >= ROWS) begin
                // scroll up one row and blank the bottom row
                for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
                    shadow_screen[i] = shadow_screen[i + COLUMNS];
                end
                for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
                    shadow_screen[i] = {shadow_attr, CH_SPACE};
                end
                shadow_row = ROWS - 1;
            end
        end else if (rq.kind == REQ_CLEAR) begin
            blank_screen();
            shadow_col = 0;
            shadow_row = 0;
        end else if (rq.kind == REQ_READ) begin
            // off-screen reads give zero
            if (rq.row < ROWS && rq.col < COLUMNS) begin
                rp.cell_word = shadow_screen[rq.row * COLUMNS + rq.col];
            end
        end
        rp.col = 7'(shadow_col);
        rp.row = 5'(shadow_row);
        return rp;
    endfunction

    // mostly text with line breaks and edits, some reads, rare clears and unused kinds;
    // fields a request does not use still carry random bits
    function automatic console_req_t random_request();
        console_req_t rq;
        int unsigned  roll;
        rq.kind = REQ_PUT;
        rq.ch   = 8'($urandom);
        rq.row  = 5'($urandom);
        rq.col  = 7'($urandom);
        roll    = $urandom_range(0, 399);
        if (roll < 1) begin
            rq.kind = REQ_CLEAR;
        end else if (roll < 80) begin
            rq.kind = REQ_READ;
            // most reads land on the screen, the rest span the whole field range
            if ($urandom_range(0, 4) != 0) begin
                rq.row = 5'($urandom_range(0, ROWS - 1));
                rq.col = 7'($urandom_range(0, COLUMNS - 1));
            end
        end else if (roll < 88) begin
            rq.kind = REQ_UNUSED;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                rq.ch = CH_NEWLINE;
            end else if (roll < 32) begin
                rq.ch = CH_RETURN;
            end else if (roll < 40) begin
                rq.ch = CH_TAB;
            end else if (roll < 50) begin
                rq.ch = CH_BACKSPACE;
            end
        end
        return rq;
    endfunction

    function automatic void queue_req(logic [1:0] kind, logic [7:0] ch, logic [4:0] row,
                                      logic [6:0] col);
        pending_reqs.push_back({kind, ch, row, col});
        queued_count++;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] exp_val, logic [31:0] act_val);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch in %s at reply %0d: expected %h, got %h",
                     what, replies_seen, exp_val, act_val);
        end
    endfunction

    // setup cycle, then access cycle; the register takes the value at the access edge
    task automatic write_text_attr(logic [7:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_TEXT_ATTR);
        pwdata  <= {24'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        shadow_attr = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // every queued beat accepted and answered, then a settling wait for the sequencer
    task automatic wait_drained();
        while (accepted_count != queued_count || expected_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    // request driver: a beat stays on the bus until taken, idle bursts fall between beats
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_accepted)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (tx_idle_on && $urandom_range(0, 3) == 0) begin
                // idle burst of random length, this one included
                tx_gap = $urandom_range(0, 8);
                s_tvalid <= 1'b0;
            end else begin
                next_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_req.kind;
                s_tdata  <= {4'd0, next_req.col, next_req.row, next_req.ch};
            end
        end
    end

    // reply sink: random stall bursts, and once a long hold-off so the block backs up
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (!hold_done && replies_seen >= HOLD_AT_REPLY) begin
            hold_done = 1'b1;
            rx_hold   = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            rx_stall = $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: check reply beats against the oldest expectation, then predict for new requests
    always @(posedge aclk) begin
        s_accepted <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
                note_mismatch("unexpected beat", 32'd0, m_tdata);
            end else begin
                want = expected_replies.pop_front();
                if (m_tdata[15:0] != want.cell_word) begin
                    note_mismatch("cell_word", 32'(want.cell_word), 32'(m_tdata[15:0]));
                end
                if (m_tdata[22:16] != want.col) begin
                    note_mismatch("cursor_col", 32'(want.col), 32'(m_tdata[22:16]));
                end
                if (m_tdata[27:23] != want.row) begin
                    note_mismatch("cursor_row", 32'(want.row), 32'(m_tdata[27:23]));
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            accepted_count++;
            expected_replies.push_back(console_step({s_tuser, s_tdata[7:0], s_tdata[12:8],
                                                     s_tdata[19:13]}));
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk) cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus sequencer
    initial begin
        logic [7:0]   next_attr;
        bit           quiet;
        console_req_t rq;

        shadow_attr = ATTR_RESET;
        blank_screen();
        shadow_col = 0;
        shadow_row = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, reset attribute; the block first runs its clearing pass
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        queue_req(REQ_READ,   8'h00,        5'd0,  7'd0);    // blank cell after reset
        queue_req(REQ_READ,   8'h00,        5'd24, 7'd79);   // last cell of the screen
        queue_req(REQ_READ,   8'h00,        5'd25, 7'd0);    // row past the bottom
        queue_req(REQ_READ,   8'hFF,        5'd31, 7'd127);  // both coordinates at field max
        queue_req(REQ_READ,   8'h00,        5'd0,  7'd80);   // column past the right edge
        queue_req(REQ_UNUSED, 8'hFF,        5'd31, 7'd127);  // ignored kind
        queue_req(REQ_PUT,    CH_BACKSPACE, 5'd0,  7'd0);    // backspace at the origin
        queue_req(REQ_PUT,    8'h41,        5'd0,  7'd0);
        queue_req(REQ_PUT,    8'hFF,        5'd0,  7'd0);    // top-bit character stays unsigned
        queue_req(REQ_PUT,    8'h00,        5'd0,  7'd0);
        queue_req(REQ_PUT,    CH_BACKSPACE, 5'd0,  7'd0);    // mid-line erase
        queue_req(REQ_READ,   8'h00,        5'd0,  7'd1);
        queue_req(REQ_PUT,    CH_TAB,       5'd0,  7'd0);
        queue_req(REQ_PUT,    CH_RETURN,    5'd0,  7'd0);
        queue_req(REQ_PUT,    CH_NEWLINE,   5'd0,  7'd0);
        queue_req(REQ_PUT,    CH_BACKSPACE, 5'd0,  7'd0);    // column zero, back to line above
        queue_req(REQ_PUT,    CH_TAB,       5'd0,  7'd0);    // tab off the right edge wraps
        queue_req(REQ_PUT,    CH_BACKSPACE, 5'd0,  7'd0);
        queue_req(REQ_PUT,    8'h5A,        5'd0,  7'd0);    // write in last column wraps
        queue_req(REQ_READ,   8'h00,        5'd0,  7'd79);
        queue_req(REQ_CLEAR,  8'h00,        5'd0,  7'd0);
        queue_req(REQ_READ,   8'h00,        5'd0,  7'd0);
        wait_drained();

        // random phases, each under a fresh attribute; the last one runs without idling
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:                 next_attr = 8'hFF;
                1:                 next_attr = 8'h00;
                RANDOM_PHASES - 1: next_attr = ATTR_RESET;
                default:           next_attr = 8'($urandom);
            endcase
            write_text_attr(next_attr);
            quiet      = (p == RANDOM_PHASES - 1);
            tx_idle_on = (p == 0) || (!quiet && $urandom_range(0, 3) != 0);
            rx_idle_on = (p == 0) || (!quiet && $urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS) begin
                rq = random_request();
                queue_req(rq.kind, rq.ch, rq.row, rq.col);
            end
            wait_drained();
        end

        // tail: catch any stray beat
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
